// ===== sv/ata_pkg.sv =====
// ----------------------------------------------------------------------------
// ata_pkg: shared types and constants for the tilt angle unit
// Payload structs, CORDIC angle table and fixed-point widths.
// ----------------------------------------------------------------------------
`default_nettype none
package ata_pkg;

  localparam int CordicStages = 16;
  localparam int RadW         = 50;   // radicand (a^2+b^2)<<16 fits 49 bits, even width
  localparam int RootW        = 25;   // root of RadW bits
  localparam int CxW          = 28;   // CORDIC x/y working width, signed
  localparam int AccW         = 25;   // angle accumulator, signed
  localparam int QDepth       = 2;

  localparam logic [AccW-1:0] Deg90Fine = AccW'(5898240);
  localparam logic [15:0]     Deg90Out  = 16'd23040;

  typedef struct packed {
    logic [7:0]         sensor_index;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pitch_deg;
    logic signed [15:0] roll_deg;
    logic               status;
  } out_item_t;

  // classified item passed from front to back
  typedef struct packed {
    logic               reject;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } cls_item_t;

  function automatic logic [AccW-1:0] atan_entry(input int i);
    logic [AccW-1:0] t;
    case (i)
      0: t = AccW'(2949120);  1: t = AccW'(1740967);  2: t = AccW'(919879);
      3: t = AccW'(466945);   4: t = AccW'(234379);   5: t = AccW'(117304);
      6: t = AccW'(58666);    7: t = AccW'(29335);    8: t = AccW'(14668);
      9: t = AccW'(7334);     10: t = AccW'(3667);    11: t = AccW'(1833);
      12: t = AccW'(917);     13: t = AccW'(458);     14: t = AccW'(229);
      15: t = AccW'(115);     16: t = AccW'(57);      17: t = AccW'(29);
      18: t = AccW'(14);      19: t = AccW'(7);       20: t = AccW'(4);
      21: t = AccW'(2);       22: t = AccW'(1);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== sv/ata_front.sv =====
// ----------------------------------------------------------------------------
// ata_front: input stage and classifier
// Accepts items, checks the sensor index and queues classified items.
// ----------------------------------------------------------------------------
`default_nettype none
module ata_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire ata_pkg::in_item_t  in_data,
  input  wire logic [7:0]         sensor_count,
  output      logic               q_valid,
  input  wire logic               q_ready,
  output      ata_pkg::cls_item_t q_data
);
  ata_pkg::cls_item_t mem_r [ata_pkg::QDepth];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;
  ata_pkg::cls_item_t cls;

  always_comb begin
    cls.reject  = (in_data.sensor_index >= sensor_count);
    cls.accel_x = in_data.accel_x;
    cls.accel_y = in_data.accel_y;
    cls.accel_z = in_data.accel_z;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> cnt_r == 2'd2) else $error("full queue lost item");
endmodule
`default_nettype wire

// ===== sv/ata_sqrt_stage.sv =====
// ----------------------------------------------------------------------------
// ata_sqrt_stage: one step of the restoring square root
// Resolves one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module ata_sqrt_stage (
  input  wire logic [ata_pkg::RadW-1:0]  rem_i,
  input  wire logic [ata_pkg::RootW-1:0] root_i,
  input  wire logic [ata_pkg::RadW-1:0]  rad_i,
  output      logic [ata_pkg::RadW-1:0]  rem_o,
  output      logic [ata_pkg::RootW-1:0] root_o,
  output      logic [ata_pkg::RadW-1:0]  rad_o
);
  logic [ata_pkg::RadW-1:0] r2, trial;
  always_comb begin
    r2    = {rem_i[ata_pkg::RadW-3:0], rad_i[ata_pkg::RadW-1 -: 2]};
    trial = {{(ata_pkg::RadW-ata_pkg::RootW-2){1'b0}}, root_i, 2'b01};
    rad_o = {rad_i[ata_pkg::RadW-3:0], 2'b00};
    if (r2 >= trial) begin
      rem_o  = r2 - trial;
      root_o = {root_i[ata_pkg::RootW-2:0], 1'b1};
    end else begin
      rem_o  = r2;
      root_o = {root_i[ata_pkg::RootW-2:0], 1'b0};
    end
  end
endmodule
`default_nettype wire

// ===== sv/ata_back.sv =====
// ----------------------------------------------------------------------------
// ata_back: pipelined square root and CORDIC for both angles
// Fixed-depth pipeline with a global advance enable and an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module ata_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  output      logic                q_ready,
  input  wire ata_pkg::cls_item_t  q_data,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      ata_pkg::out_item_t  out_data
);
  localparam int NSq = ata_pkg::RootW;        // sqrt stages
  localparam int NC  = ata_pkg::CordicStages;  // cordic stages
  localparam int NT  = 1 + NSq + NC + 1;       // total pipe stages
  localparam int W   = ata_pkg::CxW;
  localparam int A   = ata_pkg::AccW;

  typedef struct packed {
    logic                       reject;
    logic                       neg;
    logic                       nzero;
    logic [23:0]                n;
    logic [ata_pkg::RadW-1:0]   rad;
    logic [ata_pkg::RadW-1:0]   rem;
    logic [ata_pkg::RootW-1:0]  root;
    logic signed [W-1:0]        cx;
    logic signed [W-1:0]        cy;
    logic signed [A-1:0]        acc;
  } lane_t;

  logic              v_r   [NT];
  lane_t             p_r   [NT];  // pitch lane
  lane_t             q_r   [NT];  // roll lane
  lane_t             p_nxt [NT];
  lane_t             q_nxt [NT];
  logic              adv;

  // the pipe moves when the output slot is free or being drained
  assign adv     = !out_valid || out_ready;
  assign q_ready = adv;

  function automatic lane_t load(input logic rej, input logic signed [15:0] num,
                                 input logic signed [15:0] a, input logic signed [15:0] b);
    lane_t l;
    logic [15:0] mag;
    logic [31:0] sa, sb;
    l = '0;
    mag = num[15] ? 16'(-num) : 16'(num);
    sa = 32'(a * a);
    sb = 32'(b * b);
    l.reject = rej;
    l.neg   = num[15];
    l.nzero = (mag == 16'd0);
    l.n     = {mag, 8'd0};
    l.rad   = ata_pkg::RadW'({({1'b0, sa} + {1'b0, sb}), 16'd0});
    return l;
  endfunction

  function automatic lane_t cstep(input lane_t l, input int i);
    lane_t o;
    logic signed [W-1:0] tx, ty;
    o = l;
    tx = l.cx[W-1] ? -((-l.cx) >>> i) : (l.cx >>> i);
    ty = l.cy[W-1] ? -((-l.cy) >>> i) : (l.cy >>> i);
    if (!l.cy[W-1]) begin
      o.cx = l.cx + ty; o.cy = l.cy - tx; o.acc = l.acc + A'(ata_pkg::atan_entry(i));
    end else begin
      o.cx = l.cx - ty; o.cy = l.cy + tx; o.acc = l.acc - A'(ata_pkg::atan_entry(i));
    end
    return o;
  endfunction

  function automatic logic [15:0] finish(input lane_t l);
    logic signed [A-1:0] c;
    logic [15:0] r;
    c = l.acc;
    if (c < 0) c = '0;
    if (c > $signed(ata_pkg::Deg90Fine)) c = ata_pkg::Deg90Fine;
    if (l.nzero)            r = 16'd0;
    else if (l.root == '0)  r = ata_pkg::Deg90Out;
    else                    r = 16'((c + A'(128)) >>> 8);
    return l.neg ? 16'(-r) : r;
  endfunction

  // stage 0: load; stages 1..NSq: root bits; then cordic; last: out register
  genvar g;
  always_comb begin
    p_nxt[0] = load(q_data.reject, q_data.accel_x, q_data.accel_y, q_data.accel_z);
    q_nxt[0] = load(q_data.reject, q_data.accel_y, q_data.accel_x, q_data.accel_z);
  end

  for (g = 0; g < NSq; g++) begin : g_sq
    logic [ata_pkg::RadW-1:0]  p_rem, p_rad, q_rem, q_rad;
    logic [ata_pkg::RootW-1:0] p_root, q_root;
    ata_sqrt_stage u_sp (.rem_i(p_r[g].rem), .root_i(p_r[g].root), .rad_i(p_r[g].rad),
      .rem_o(p_rem), .root_o(p_root), .rad_o(p_rad));
    ata_sqrt_stage u_sr (.rem_i(q_r[g].rem), .root_i(q_r[g].root), .rad_i(q_r[g].rad),
      .rem_o(q_rem), .root_o(q_root), .rad_o(q_rad));
    always_comb begin
      p_nxt[g+1]      = p_r[g];
      p_nxt[g+1].rem  = p_rem;
      p_nxt[g+1].root = p_root;
      p_nxt[g+1].rad  = p_rad;
      q_nxt[g+1]      = q_r[g];
      q_nxt[g+1].rem  = q_rem;
      q_nxt[g+1].root = q_root;
      q_nxt[g+1].rad  = q_rad;
    end
  end

  for (g = 0; g < NC; g++) begin : g_cd
    always_comb begin
      lane_t pl, ql;
      pl = p_r[NSq+g];
      ql = q_r[NSq+g];
      if (g == 0) begin
        pl.cx = W'(pl.root); pl.cy = W'(pl.n); pl.acc = '0;
        ql.cx = W'(ql.root); ql.cy = W'(ql.n); ql.acc = '0;
      end
      p_nxt[NSq+g+1] = cstep(pl, g);
      q_nxt[NSq+g+1] = cstep(ql, g);
    end
  end

  always_comb begin
    p_nxt[NT-1] = p_r[NT-2];
    q_nxt[NT-1] = q_r[NT-2];
  end

  for (g = 0; g < NT; g++) begin : g_reg
    always_ff @(posedge clk) begin
      if (adv) begin
        p_r[g] <= p_nxt[g];
        q_r[g] <= q_nxt[g];
      end
      if (!rst_n)   v_r[g] <= 1'b0;
      else if (adv) v_r[g] <= (g == 0) ? q_valid : v_r[(g == 0) ? 0 : g-1];
    end
  end

  assign out_valid = v_r[NT-1];
  always_comb begin
    out_data.status    = p_r[NT-1].reject;
    out_data.pitch_deg = p_r[NT-1].reject ? 16'sd0 : finish(p_r[NT-1]);
    out_data.roll_deg  = q_r[NT-1].reject ? 16'sd0 : finish(q_r[NT-1]);
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_data)) else $error("result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    q_ready == adv) else $error("pipe advance mismatch");
endmodule
`default_nettype wire

// ===== sv/accel_tilt_angles_unit.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_angles_unit: pitch and roll from one accelerometer sample
// Front queue classifies items; back pipeline computes sqrt and CORDIC atan.
// ----------------------------------------------------------------------------
//  channel   signals                         direction
//  in        in_valid/in_ready/in_data       sample item in
//  out       out_valid/out_ready/out_data    angle item out
//  cfg       cfg_we/cfg_wdata                sensor_count write
//
// One item per cycle sustained while the output is not stalled. An accepted
// item passes one entry of the two-entry front queue, then the back pipeline
// (load, 25 root stages, 16 CORDIC stages, output register) to result valid.
// Reset sets sensor_count to 1 and empties everything. A stalled output
// freezes the whole back pipeline; the queue keeps taking items until full.
// ----------------------------------------------------------------------------
`default_nettype none
module accel_tilt_angles_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire ata_pkg::in_item_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      ata_pkg::out_item_t out_data,
  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_wdata
);
  logic [7:0]         sensor_count_r;
  logic               q_valid, q_ready;
  ata_pkg::cls_item_t q_data;

  // hold the sensor count; write takes effect next cycle
  always_ff @(posedge clk) begin
    if (!rst_n)      sensor_count_r <= 8'd1;
    else if (cfg_we) sensor_count_r <= cfg_wdata;
  end

  ata_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .sensor_count(sensor_count_r),
    .q_valid, .q_ready, .q_data
  );

  ata_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire
